// ===== sv/plane_hit_centroid_summary_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the plane hit centroid summary core
// ---------------------------------------------------------------------------
`ifndef PLANE_HIT_CENTROID_SUMMARY_CORE_DEFINES_SVH
`define PLANE_HIT_CENTROID_SUMMARY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PHCS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define PHCS_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PHCS_ASSERT(label, clk, rstn, prop)
`define PHCS_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/phcs_pkg.sv =====
// ---------------------------------------------------------------------------
// phcs_pkg
// Payload types and register indexes of the plane hit centroid summary core.
// ---------------------------------------------------------------------------
package phcs_pkg;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_T_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_THR  = 3'd6;

  typedef struct packed {
    logic [3:0]         bar_number;
    logic               large_sensor;
    logic signed [15:0] charge;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] hit_time;
    logic               last_hit;
  } hit_t;

  typedef struct packed {
    logic signed [15:0] centroid_x;
    logic signed [15:0] centroid_y;
    logic signed [15:0] centroid_z;
    logic [15:0]        err_x;
    logic [15:0]        err_y;
    logic [15:0]        err_z;
    logic               centroid_valid;
    logic signed [39:0] charge_large_total;
    logic signed [39:0] charge_small_total;
    logic [8:0]         count_large;
    logic [8:0]         count_small;
    logic [4:0]         bars_hit;
  } summary_t;

endpackage

// ===== sv/plane_hit_centroid_summary_core.sv =====
// ---------------------------------------------------------------------------
// plane_hit_centroid_summary_core
// Charge-weighted centroid and charge/count summary of one detector plane.
// ---------------------------------------------------------------------------
// Usage:
//   Hits enter on hit_valid_i/hit_stall_o, one transfer per hit. Summaries
//   leave on sum_valid_o/sum_stall_i, one per hit that carries last_hit.
//   A hit that is not the last is accepted in idle, then accumulated.
//   A qualifying large hit then makes one pass per product on the single
//   shared 17x33 multiplier (charge*x, charge*y, charge*z, charge^2).
//   A last hit runs the end-of-event sequence on the same shared unit:
//   bar scan over all BARS bars, 32-step square root, three 64-step restoring
//   divides for the centroids and three for the errors. When no centroid
//   is formed, the sequence ends after the bar scan.
//   The summary sits in an output register; the next event's hits are
//   accepted while it waits. A further last hit waits until it is taken.
//   Reset clears all event sums and loads the register defaults.
//   Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i while idle; the core does not enforce this.
// ---------------------------------------------------------------------------
`include "plane_hit_centroid_summary_core_defines.svh"

module plane_hit_centroid_summary_core #(
  parameter int unsigned BARS     = 16,
  parameter int unsigned MAX_HITS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [phcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [phcs_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                hit_valid_i,
  output logic                                hit_stall_o,
  input  phcs_pkg::hit_t                      hit_i,
  output logic                                sum_valid_o,
  input  logic                                sum_stall_i,
  output phcs_pkg::summary_t                  sum_o
);
  import phcs_pkg::*;

  localparam int unsigned BW = (BARS > 1) ? $clog2(BARS) : 1;
  localparam logic [8:0] CNT_SAT = (MAX_HITS < 511) ? 9'(MAX_HITS) : 9'd511;
  localparam logic signed [39:0] MAX40 = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] MIN40 = {1'b1, {39{1'b0}}};
  localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_ACC  = 11'b00000000010,
    ST_MUL  = 11'b00000000100,
    ST_END  = 11'b00000001000,
    ST_SCAN = 11'b00000010000,
    ST_SQRT = 11'b00000100000,
    ST_DIVC = 11'b00001000000,
    ST_RNDC = 11'b00010000000,
    ST_EMUL = 11'b00100000000,
    ST_DIVE = 11'b01000000000,
    ST_OUT  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [8:0]         min_hits_q;
  logic [15:0]        esc_q [3];
  logic signed [15:0] t_low_q, t_high_q;
  logic [4:0]         bar_thr_q;

  // event state
  logic signed [47:0] wsum_q [3];
  logic signed [39:0] qsum_q, lq_q, sq_q;
  logic [39:0]        qsq_q;
  logic [8:0]         qcnt_q, lcnt_q, scnt_q;
  logic [4:0]         per_bar_q [BARS];

  hit_t               hit_q;
  logic [1:0]         sel_q;
  logic [8:0]         step_q;
  logic [4:0]         bars_q;

  // shared iterative datapath
  logic [63:0]        rem_q;     // sqrt remainder / divide remainder
  logic [63:0]        quo_q;     // sqrt root / divide quotient / dividend shift
  logic [63:0]        op_q;      // sqrt operand bits / divisor
  logic               neg_q;
  logic [39:0]        root_q;

  summary_t           out_q;
  logic               out_v_q;

  wire hit_acc = hit_valid_i && !hit_stall_o;
  wire out_acc = out_v_q && !sum_stall_i;

  assign hit_stall_o = (state_q != ST_IDLE) || (hit_i.last_hit && out_v_q);
  assign sum_valid_o = out_v_q;
  assign sum_o       = out_q;

  wire in_win = (hit_q.hit_time >= t_low_q) && (hit_q.hit_time <= t_high_q);
  wire qual   = in_win && hit_q.large_sensor && (hit_q.charge > 16'sd0);

  // shared multiplier: 17 x 33 signed, also serves the unsigned error scale
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [48:0] mul_p;
  always_comb begin
    mul_a = 17'(hit_q.charge);
    case (sel_q)
      2'd0: mul_b = 33'(signed'(hit_q.pos_x));
      2'd1: mul_b = 33'(signed'(hit_q.pos_y));
      2'd2: mul_b = 33'(signed'(hit_q.pos_z));
      default: mul_b = 33'(signed'(hit_q.charge));
    endcase
    if (state_q == ST_EMUL) begin
      // root <= 2^31, so scale * root stays below 2^47
      mul_a = signed'({1'b0, esc_q[sel_q]});
      mul_b = signed'({1'b0, root_q[31:0]});
    end
    mul_p = 49'(mul_a * mul_b);
  end

  wire valid_c = (qcnt_q >= min_hits_q) && (qsum_q > 40'sd0);

  // divide step: remainder/divisor compare
  wire [64:0] rem_sh   = {rem_q, quo_q[63]};
  wire [64:0] rem_sub  = rem_sh - {1'b0, op_q};
  // sqrt step
  wire [65:0] sq_rem   = {rem_q, op_q[63:62]};
  wire [65:0] sq_try   = {quo_q[63:0], 2'b01};
  wire [65:0] sq_sub   = sq_rem - sq_try;

  logic [47:0] ws_mag;
  always_comb begin
    ws_mag = wsum_q[sel_q][47] ? 48'(-wsum_q[sel_q]) : 48'(wsum_q[sel_q]);
  end

  logic [47:0] ws_next_mag;
  logic        ws_next_neg;
  always_comb begin
    ws_next_neg = wsum_q[2'(sel_q + 2'd1)][47];
    ws_next_mag = ws_next_neg ? 48'(-wsum_q[2'(sel_q + 2'd1)])
                              : 48'(wsum_q[2'(sel_q + 2'd1)]);
  end

  // rounding dividend 2|w| + d over divisor 2d
  wire [63:0] cdiv_num  = {15'd0, ws_mag, 1'b0} + {24'd0, qsum_q};
  wire [63:0] cdiv_next = {15'd0, ws_next_mag, 1'b0} + {24'd0, qsum_q};

  wire [15:0] e_sat = (quo_q[62:15] != '0) ? 16'hffff : {quo_q[14:0], !rem_sub[64]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (hit_acc) state_d = ST_ACC;
      ST_ACC:  state_d = qual ? ST_MUL : (hit_q.last_hit ? ST_END : ST_IDLE);
      ST_MUL:  if (sel_q == 2'd3) state_d = hit_q.last_hit ? ST_END : ST_IDLE;
      ST_END:  state_d = ST_SCAN;
      ST_SCAN: if (step_q == 9'(BARS - 1)) state_d = valid_c ? ST_SQRT : ST_OUT;
      ST_SQRT: if (step_q == 9'd31) state_d = ST_DIVC;
      ST_DIVC: if (step_q == 9'd63) state_d = ST_RNDC;
      ST_RNDC: state_d = (sel_q == 2'd2) ? ST_EMUL : ST_DIVC;
      ST_EMUL: state_d = ST_DIVE;
      ST_DIVE: if (step_q == 9'd63) state_d = (sel_q == 2'd2) ? ST_OUT : ST_EMUL;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      min_hits_q <= 9'd1;
      esc_q[0]   <= 16'd256;
      esc_q[1]   <= 16'd256;
      esc_q[2]   <= 16'd256;
      t_low_q    <= 16'sh8000;
      t_high_q   <= 16'sh7fff;
      bar_thr_q  <= 5'd0;
      wsum_q[0]  <= '0;
      wsum_q[1]  <= '0;
      wsum_q[2]  <= '0;
      qsum_q     <= '0;
      qsq_q      <= '0;
      qcnt_q     <= '0;
      lq_q       <= '0;
      sq_q       <= '0;
      lcnt_q     <= '0;
      scnt_q     <= '0;
      for (int b = 0; b < BARS; b++) per_bar_q[b] <= '0;
      out_v_q    <= 1'b0;
      sel_q      <= '0;
      step_q     <= '0;
      bars_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_HITS: min_hits_q <= cfg_data_i[8:0];
          REG_ERR_X:    esc_q[0]   <= cfg_data_i;
          REG_ERR_Y:    esc_q[1]   <= cfg_data_i;
          REG_ERR_Z:    esc_q[2]   <= cfg_data_i;
          REG_T_LOW:    t_low_q    <= signed'(cfg_data_i);
          REG_T_HIGH:   t_high_q   <= signed'(cfg_data_i);
          REG_BAR_THR:  bar_thr_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (out_acc) out_v_q <= 1'b0;
      case (state_q)
        ST_ACC: begin
          sel_q <= '0;
          if (in_win) begin
            if (hit_q.large_sensor) begin
              lq_q <= ((41'(lq_q) + 41'(hit_q.charge)) > 41'(MAX40)) ? MAX40 :
                      ((41'(lq_q) + 41'(hit_q.charge)) < 41'(MIN40)) ? MIN40 :
                      40'(lq_q + 40'(hit_q.charge));
              if (lcnt_q < CNT_SAT) lcnt_q <= lcnt_q + 9'd1;
              if (32'(hit_q.bar_number) < BARS) begin
                if (per_bar_q[BW'(hit_q.bar_number)] != 5'd31)
                  per_bar_q[BW'(hit_q.bar_number)] <= per_bar_q[BW'(hit_q.bar_number)] + 5'd1;
              end
              if (hit_q.charge > 16'sd0) begin
                qsum_q <= ((41'(qsum_q) + 41'(hit_q.charge)) > 41'(MAX40)) ? MAX40 :
                          40'(qsum_q + 40'(hit_q.charge));
                if (qcnt_q < CNT_SAT) qcnt_q <= qcnt_q + 9'd1;
              end
            end else begin
              sq_q <= ((41'(sq_q) + 41'(hit_q.charge)) > 41'(MAX40)) ? MAX40 :
                      ((41'(sq_q) + 41'(hit_q.charge)) < 41'(MIN40)) ? MIN40 :
                      40'(sq_q + 40'(hit_q.charge));
              if (scnt_q < CNT_SAT) scnt_q <= scnt_q + 9'd1;
            end
          end
        end
        ST_MUL: begin
          sel_q <= sel_q + 2'd1;
          if (sel_q == 2'd3) begin
            qsq_q <= ((41'(qsq_q) + 41'(mul_p[31:0])) > 41'({40{1'b1}})) ? {40{1'b1}} :
                     40'(qsq_q + 40'(mul_p[31:0]));
          end else begin
            wsum_q[sel_q] <= ((49'(wsum_q[sel_q]) + mul_p) > 49'(MAX48)) ? MAX48 :
                             ((49'(wsum_q[sel_q]) + mul_p) < 49'(MIN48)) ? MIN48 :
                             48'(49'(wsum_q[sel_q]) + mul_p);
          end
        end
        ST_END: begin
          step_q <= '0;
          bars_q <= '0;
        end
        ST_SCAN: begin
          if (per_bar_q[BW'(step_q)] > bar_thr_q && bars_q != 5'd31) bars_q <= bars_q + 5'd1;
          if (step_q == 9'(BARS - 1)) begin
            step_q <= '0;
            rem_q  <= '0;
            quo_q  <= '0;
            op_q   <= {2'b00, qsq_q, 22'd0};
            sel_q  <= '0;
          end else begin
            step_q <= step_q + 9'd1;
          end
        end
        ST_SQRT: begin
          // two operand bits per step, one root bit
          if (step_q == 9'd31) begin
            root_q <= 40'({quo_q[62:0], !sq_sub[65]});
            step_q <= '0;
            rem_q  <= '0;
            quo_q  <= cdiv_num;
            op_q   <= {23'd0, qsum_q[39:0], 1'b0};  // 2*d
            neg_q  <= wsum_q[sel_q][47];
          end else begin
            op_q <= {op_q[61:0], 2'b00};
            if (!sq_sub[65]) begin
              rem_q <= sq_sub[63:0];
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= sq_rem[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
            step_q <= step_q + 9'd1;
          end
        end
        ST_DIVC: begin
          if (!rem_sub[64]) begin
            rem_q <= rem_sub[63:0];
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= rem_sh[63:0];
            quo_q <= {quo_q[62:0], 1'b0};
          end
          step_q <= step_q + 9'd1;
        end
        ST_RNDC: begin
          step_q <= '0;
          case (sel_q)
            2'd0: out_q.centroid_x <= (neg_q ? ((quo_q > 64'd32768) ? 16'sh8000 :
                    16'(-quo_q[15:0])) : ((quo_q > 64'd32767) ? 16'sh7fff : quo_q[15:0]));
            2'd1: out_q.centroid_y <= (neg_q ? ((quo_q > 64'd32768) ? 16'sh8000 :
                    16'(-quo_q[15:0])) : ((quo_q > 64'd32767) ? 16'sh7fff : quo_q[15:0]));
            default: out_q.centroid_z <= (neg_q ? ((quo_q > 64'd32768) ? 16'sh8000 :
                    16'(-quo_q[15:0])) : ((quo_q > 64'd32767) ? 16'sh7fff : quo_q[15:0]));
          endcase
          if (sel_q == 2'd2) begin
            sel_q <= '0;
          end else begin
            sel_q <= sel_q + 2'd1;
            rem_q <= '0;
            quo_q <= cdiv_next;
            neg_q <= ws_next_neg;
          end
        end
        ST_EMUL: begin
          step_q <= '0;
          rem_q  <= '0;
          quo_q  <= {16'd0, mul_p[47:0]};
          op_q   <= {13'd0, qsum_q[39:0], 11'd0};
        end
        ST_DIVE: begin
          if (step_q == 9'd63) begin
            step_q <= '0;
            case (sel_q)
              2'd0: out_q.err_x <= e_sat;
              2'd1: out_q.err_y <= e_sat;
              default: out_q.err_z <= e_sat;
            endcase
            sel_q <= sel_q + 2'd1;
          end else begin
            if (!rem_sub[64]) begin
              rem_q <= rem_sub[63:0];
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
            step_q <= step_q + 9'd1;
          end
        end
        ST_OUT: begin
          out_v_q <= 1'b1;
          out_q.centroid_valid     <= valid_c;
          if (!valid_c) begin
            out_q.centroid_x <= '0;
            out_q.centroid_y <= '0;
            out_q.centroid_z <= '0;
            out_q.err_x      <= '0;
            out_q.err_y      <= '0;
            out_q.err_z      <= '0;
          end
          out_q.charge_large_total <= lq_q;
          out_q.charge_small_total <= sq_q;
          out_q.count_large        <= lcnt_q;
          out_q.count_small        <= scnt_q;
          out_q.bars_hit           <= bars_q;
          wsum_q[0] <= '0;
          wsum_q[1] <= '0;
          wsum_q[2] <= '0;
          qsum_q    <= '0;
          qsq_q     <= '0;
          qcnt_q    <= '0;
          lq_q      <= '0;
          sq_q      <= '0;
          lcnt_q    <= '0;
          scnt_q    <= '0;
          for (int b = 0; b < BARS; b++) per_bar_q[b] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_acc) hit_q <= hit_i;
  end

  `PHCS_ASSERT(a_out_hold, clk_i, rst_ni, (out_v_q && sum_stall_i) |=> out_v_q)
  `PHCS_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != ST_IDLE) |-> hit_stall_o)
  `PHCS_ASSERT(a_out_from_end, clk_i, rst_ni, $rose(out_v_q) |-> $past(state_q == ST_OUT))

endmodule

// ===== sim/plane_hit_centroid_summary_checker.sv =====
// ---------------------------------------------------------------------------
// plane_hit_centroid_summary_checker
// Watches the hit, summary and register ports of the centroid summary core,
// keeps its own copy of the event sums, predicts each summary and compares.
// ---------------------------------------------------------------------------
module plane_hit_centroid_summary_checker #(
  parameter int unsigned BARS     = 16,
  parameter int unsigned MAX_HITS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [phcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [phcs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           hit_valid_i,
  input  logic                           hit_stall_i,
  input  phcs_pkg::hit_t                 hit_i,
  input  logic                           sum_valid_i,
  input  logic                           sum_stall_i,
  input  phcs_pkg::summary_t             sum_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import phcs_pkg::*;

  localparam longint LIM40 = 64'sd549755813887;
  localparam longint LIM48 = 64'sd140737488355327;
  localparam longint unsigned SQ_MAX = 64'd1099511627775;
  localparam int unsigned CNT_SAT = (MAX_HITS < 511) ? MAX_HITS : 511;

  // register copy
  int unsigned min_hits = 1;
  longint      base_err [3] = '{256, 256, 256};
  longint      win_lo = -32768;
  longint      win_hi = 32767;
  int unsigned bar_thr = 0;

  // event sums
  longint          wsum [3];
  longint          qual_q, large_q, small_q;
  longint unsigned qual_q2;
  int unsigned     qual_n, large_n, small_n;
  int unsigned     bar_large [BARS];

  summary_t expected_summaries [$];
  int fails = 0;
  int checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_summaries.size();
  assign checked_o    = checked;

  function automatic longint sat_add(longint a, longint b, longint lim);
    longint s;
    s = a + b;
    if (s > lim) return lim;
    if (s < -lim - 1) return -lim - 1;
    return s;
  endfunction

  function automatic int unsigned sat_inc(int unsigned c, int unsigned lim);
    return (c < lim) ? c + 1 : lim;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // nearest, ties away from zero, clamped to 16 bit signed
  function automatic logic [15:0] centroid_div(longint w, longint d);
    longint unsigned mag, q;
    mag = (w < 0) ? longint'(-w) : longint'(w);
    q = (2 * mag + d) / (2 * d);
    if (w < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  function automatic void clear_event();
    wsum = '{0, 0, 0};
    qual_q = 0; large_q = 0; small_q = 0; qual_q2 = 0;
    qual_n = 0; large_n = 0; small_n = 0;
    foreach (bar_large[b]) bar_large[b] = 0;
  endfunction

  initial clear_event();

  function automatic void accumulate(hit_t h);
    longint q, t;
    longint pos [3];
    summary_t s;
    longint unsigned root, den, e;
    int unsigned bars;
    q = longint'(h.charge);
    t = longint'(h.hit_time);
    pos = '{longint'(h.pos_x), longint'(h.pos_y), longint'(h.pos_z)};
    if (t >= win_lo && t <= win_hi) begin
      if (h.large_sensor) begin
        large_q = sat_add(large_q, q, LIM40);
        large_n = sat_inc(large_n, CNT_SAT);
        if (h.bar_number < BARS) bar_large[h.bar_number] = sat_inc(bar_large[h.bar_number], 31);
        if (q > 0) begin
          for (int k = 0; k < 3; k++) wsum[k] = sat_add(wsum[k], pos[k] * q, LIM48);
          qual_q = sat_add(qual_q, q, LIM40);
          qual_q2 = (SQ_MAX - qual_q2 < q * q) ? SQ_MAX : qual_q2 + q * q;
          qual_n = sat_inc(qual_n, CNT_SAT);
        end
      end else begin
        small_q = sat_add(small_q, q, LIM40);
        small_n = sat_inc(small_n, CNT_SAT);
      end
    end
    if (!h.last_hit) return;
    s = '0;
    s.centroid_valid = (qual_n >= min_hits) && (qual_q > 0);
    if (s.centroid_valid) begin
      root = int_sqrt(qual_q2 << 22);
      den = longint'(qual_q) << 11;
      s.centroid_x = centroid_div(wsum[0], qual_q);
      s.centroid_y = centroid_div(wsum[1], qual_q);
      s.centroid_z = centroid_div(wsum[2], qual_q);
      e = base_err[0] * root / den; s.err_x = (e > 65535) ? 16'hffff : 16'(e);
      e = base_err[1] * root / den; s.err_y = (e > 65535) ? 16'hffff : 16'(e);
      e = base_err[2] * root / den; s.err_z = (e > 65535) ? 16'hffff : 16'(e);
    end
    bars = 0;
    foreach (bar_large[b]) if (bar_large[b] > bar_thr) bars++;
    s.bars_hit = (bars > 31) ? 5'd31 : 5'(bars);
    s.charge_large_total = 40'(large_q);
    s.charge_small_total = 40'(small_q);
    s.count_large = 9'(large_n);
    s.count_small = 9'(small_n);
    expected_summaries = {expected_summaries, s};
    clear_event();
  endfunction

  function automatic void cmp(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    summary_t e;
    if (rst_ni) begin
      if (sum_valid_i && !sum_stall_i) begin
        if (expected_summaries.size() == 0) begin
          $error("summary transfer with no summary pending");
          fails++;
        end else begin
          e = expected_summaries.pop_front();
          checked++;
          cmp("centroid_x", e.centroid_x, sum_i.centroid_x);
          cmp("centroid_y", e.centroid_y, sum_i.centroid_y);
          cmp("centroid_z", e.centroid_z, sum_i.centroid_z);
          cmp("err_x", e.err_x, sum_i.err_x);
          cmp("err_y", e.err_y, sum_i.err_y);
          cmp("err_z", e.err_z, sum_i.err_z);
          cmp("centroid_valid", e.centroid_valid, sum_i.centroid_valid);
          cmp("charge_large_total", e.charge_large_total, sum_i.charge_large_total);
          cmp("charge_small_total", e.charge_small_total, sum_i.charge_small_total);
          cmp("count_large", e.count_large, sum_i.count_large);
          cmp("count_small", e.count_small, sum_i.count_small);
          cmp("bars_hit", e.bars_hit, sum_i.bars_hit);
        end
      end
      if (hit_valid_i && !hit_stall_i) accumulate(hit_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_HITS: min_hits = cfg_data_i[8:0];
          REG_ERR_X:    base_err[0] = cfg_data_i;
          REG_ERR_Y:    base_err[1] = cfg_data_i;
          REG_ERR_Z:    base_err[2] = cfg_data_i;
          REG_T_LOW:    win_lo = longint'($signed(cfg_data_i));
          REG_T_HIGH:   win_hi = longint'($signed(cfg_data_i));
          REG_BAR_THR:  bar_thr = cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus for the plane hit centroid summary core: directed edge events,
// then random events over several register settings, with random gaps on
// the hit side and random stalls on the summary side.
// ---------------------------------------------------------------------------
module tb;
  import phcs_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 hit_valid_i = 1'b0;
  logic                 hit_stall_o;
  hit_t                 hit_i = '0;
  logic                 sum_valid_o;
  logic                 sum_stall_i = 1'b0;
  summary_t             sum_o;

  int fail_count, pending, checked;
  int hits_sent = 0;
  int gap_pct = 30;
  int stall_pct = 30;
  int stall_left = 0;
  int win_lo = -32768;
  int win_hi = 32767;

  always #10 clk_i = ~clk_i;

  plane_hit_centroid_summary_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .hit_valid_i, .hit_stall_o, .hit_i, .sum_valid_o, .sum_stall_i, .sum_o
  );

  plane_hit_centroid_summary_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .hit_valid_i, .hit_stall_i(hit_stall_o), .hit_i,
    .sum_valid_i(sum_valid_o), .sum_stall_i, .sum_i(sum_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  function automatic int pick_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    return ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= pick_len(stall_pct);
      sum_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_hit(hit_t h);
    int g;
    g = pick_len(gap_pct);
    @(negedge clk_i);
    if (g > 0) begin
      hit_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    hit_valid_i <= 1'b1;
    hit_i <= h;
    do @(posedge clk_i); while (hit_stall_o);
    hits_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drain outstanding summaries and let the end-of-event unit finish
  task automatic settle();
    @(negedge clk_i);
    hit_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_regs(int mh, int ex, int ey, int ez, int lo, int hi, int thr);
    write_reg(REG_MIN_HITS, mh);
    write_reg(REG_ERR_X, ex);
    write_reg(REG_ERR_Y, ey);
    write_reg(REG_ERR_Z, ez);
    write_reg(REG_T_LOW, lo);
    write_reg(REG_T_HIGH, hi);
    write_reg(REG_BAR_THR, thr);
    win_lo = lo;
    win_hi = hi;
  endtask

  function automatic hit_t rand_hit(bit last, int bar_span);
    hit_t h;
    h.bar_number = 4'($urandom_range(bar_span));
    h.large_sensor = ($urandom_range(9) < 7);
    case ($urandom_range(9))
      0: h.charge = 16'sh7fff;
      1: h.charge = 16'sh8000;
      2, 3: h.charge = 16'($urandom);
      default: h.charge = 16'($urandom_range(1, 4000));
    endcase
    h.pos_x = 16'($urandom);
    h.pos_y = 16'($urandom);
    h.pos_z = 16'($urandom);
    if (win_lo <= win_hi && $urandom_range(9) < 8)
      h.hit_time = 16'($urandom_range(win_hi - win_lo) + win_lo);
    else
      h.hit_time = 16'($urandom);
    h.last_hit = last;
    return h;
  endfunction

  task automatic run_event(int len);
    int span;
    span = $urandom_range(15);
    for (int i = 0; i < len; i++) send_hit(rand_hit(i == len - 1, span));
  endtask

  function automatic hit_t mk(int bar, bit lg, int q, int x, int y, int z, int t, bit last);
    hit_t h;
    h.bar_number = 4'(bar); h.large_sensor = lg; h.charge = 16'(q);
    h.pos_x = 16'(x); h.pos_y = 16'(y); h.pos_z = 16'(z);
    h.hit_time = 16'(t); h.last_hit = last;
    return h;
  endfunction

  initial begin
    int len, lo, hi;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part with register defaults
    send_hit(mk(0, 1, 32767, 32767, 32767, 32767, -32768, 0));
    send_hit(mk(15, 1, 32767, -32768, -32768, -32768, 32767, 0));
    send_hit(mk(3, 1, -32768, 100, -100, 0, 0, 0));
    send_hit(mk(15, 0, 32767, 0, 0, 0, 0, 0));
    send_hit(mk(7, 0, -32768, 0, 0, 0, 0, 1));
    send_hit(mk(1, 0, 500, 5, 5, 5, 0, 1));            // no qualifying charge
    send_hit(mk(2, 1, 1, -3, 3, -1, 0, 1));             // exact centroids; the next event ties in rounding
    send_hit(mk(2, 1, 2, -1, 1, 3, 0, 0));
    send_hit(mk(2, 1, 2, 2, -2, 0, 0, 1));
    send_hit(mk(4, 1, 0, 9, 9, 9, 0, 1));               // zero charge, large
    settle();
    // narrow window: dropped last hit and out-of-window hits
    set_regs(0, 65535, 0, 1, 0, 100, 16);
    send_hit(mk(5, 1, 1000, 10, 20, 30, 50, 0));
    send_hit(mk(5, 1, 1000, 10, 20, 30, 101, 0));
    send_hit(mk(6, 0, 700, 0, 0, 0, -1, 0));
    send_hit(mk(6, 1, 900, 1, 1, 1, 200, 1));
    send_hit(mk(9, 0, 10, 0, 0, 0, 0, 1));              // min 0, no charge
    settle();
    // empty window, threshold max, unreachable count
    set_regs(511, 1, 65535, 256, 10, -10, 31);
    send_hit(mk(1, 1, 400, 1, 2, 3, 0, 0));
    send_hit(mk(1, 1, 400, 1, 2, 3, 0, 1));
    settle();

    for (int phase = 0; hits_sent < 1050; phase++) begin
      case (phase % 5)
        0: set_regs(256, 65535, 65535, 65535, -32768, 32767, 16);
        1: set_regs(0, 0, 0, 0, -32768, 32767, 0);
        2: set_regs(1, 256, 256, 256, -32768, 32767, 0);
        default: begin
          lo = $urandom_range(65535) - 32768;
          hi = ($urandom_range(5) == 0) ? lo - 1 - $urandom_range(100)
             : lo + $urandom_range(65535);
          if (hi > 32767) hi = 32767;
          if (hi < -32768) hi = -32768;
          set_regs($urandom_range(6), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535), lo, hi, $urandom_range(4));
        end
      endcase
      gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
      stall_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 60);
      for (int n = 0; n < 120 && hits_sent < 1050; n += len) begin
        len = ($urandom_range(29) == 0) ? $urandom_range(260, 300) : $urandom_range(1, 12);
        if (len > 1050 - hits_sent) len = 1050 - hits_sent;
        run_event(len);
      end
      settle();
    end

    $display("%0d hits sent over several register settings, %0d summaries checked",
             hits_sent, checked);
    if (fail_count == 0)
      $display("plane_hit_centroid_summary_core test passed");
    else
      $display("plane_hit_centroid_summary_core test failed");
    $finish;
  end

  initial begin
    #100000000;
    $display("plane_hit_centroid_summary_core test failed");
    $finish;
  end

endmodule
